// File: sv/ktbe_pkg.sv
// Shared constants, register codes and helpers for the tilt/bias estimator.
package ktbe_pkg;
  localparam int FracBitsDefault = 16;
  localparam int DataW = 32;
  localparam int AccW = 66;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_Q_BIAS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_R       = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DT      = 2'd3;

  localparam logic [30:0] RST_Q_ANGLE = 31'd66;
  localparam logic [30:0] RST_Q_BIAS  = 31'd197;
  localparam logic [30:0] RST_R       = 31'd32768;
  localparam logic [16:0] RST_DT      = 17'd655;

  // saturate a wide signed value to the 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(signed'(33'sh0_7FFF_FFFF));
    lo = -AccW'(signed'(33'sh0_8000_0000));
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[DataW-1:0];
  endfunction
endpackage

// File: sv/kalman_tilt_bias_estimator_unit.sv
// Two-state Kalman tilt estimator: angle and gyro bias with 2x2 covariance.
// A bit-serial shift-add multiplier (one multiplier bit per cycle, twelve products)
// and a restoring divider (one quotient bit per cycle, 33 + FRAC_BITS bits, two
// gains) are shared by every step of the sequencer, plus three steps (S_D, S_PRED,
// S_DONE) that use neither unit. One item is in flight at a time; the result
// register holds until taken, and the next sample is accepted once the result has
// been handed off.
// Register writes are taken only while idle and win over a waiting sample.
module kalman_tilt_bias_estimator_unit #(
  parameter int FRAC_BITS = ktbe_pkg::FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [ktbe_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ktbe_pkg::CfgDataW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] gyro_rate,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] bias_estimate
);
  import ktbe_pkg::*;

  localparam int MulW = 34;
  localparam int MCntW = $clog2(MulW + 1);
  localparam int QW = 33 + FRAC_BITS;
  localparam int QCntW = $clog2(QW + 1);

  // sequencer steps
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_D    = 5'd1;
  localparam logic [4:0] S_ANG  = 5'd2;
  localparam logic [4:0] S_M10  = 5'd3;
  localparam logic [4:0] S_M01  = 5'd4;
  localparam logic [4:0] S_M11  = 5'd5;
  localparam logic [4:0] S_M11B = 5'd6;
  localparam logic [4:0] S_MQB  = 5'd7;
  localparam logic [4:0] S_PRED = 5'd8;
  localparam logic [4:0] S_DIV0 = 5'd9;
  localparam logic [4:0] S_DIV1 = 5'd10;
  localparam logic [4:0] S_KY0  = 5'd11;
  localparam logic [4:0] S_KY1  = 5'd12;
  localparam logic [4:0] S_KN0  = 5'd13;
  localparam logic [4:0] S_KN1  = 5'd14;
  localparam logic [4:0] S_KN2  = 5'd15;
  localparam logic [4:0] S_KN3  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [30:0] q_angle, q_bias, r_noise;
  logic [16:0] dt;

  logic [4:0] state;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] z, rate, d, y, k0, k1;
  logic signed [31:0] n00, n01, n10, n11;
  logic signed [AccW-1:0] t10, t01, t11, tqb;

  // shared bit-serial multiplier
  logic mbusy;
  logic [MCntW-1:0] mcnt;
  logic signed [AccW-1:0] macc, mcand;
  logic [MulW-1:0] mplier;
  logic signed [AccW-1:0] mres;

  // shared restoring divider (magnitudes)
  logic dbusy;
  logic [QCntW-1:0] dcnt;
  logic [QW-1:0] dnum, dquo;
  logic [32:0] drem, dden;
  logic dneg;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready = (state == S_IDLE) && !cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= RST_Q_ANGLE;
      q_bias <= RST_Q_BIAS;
      r_noise <= RST_R;
      dt <= RST_DT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_Q_ANGLE: q_angle <= cfg_data[30:0];
        REG_Q_BIAS:  q_bias <= cfg_data[30:0];
        REG_R:       r_noise <= cfg_data[30:0];
        REG_DT:      dt <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // rounded, floor-shifted product
  logic signed [AccW-1:0] half;
  assign half = AccW'(1) <<< (FRAC_BITS - 1);
  assign mres = (macc + half) >>> FRAC_BITS;

  logic mstart;
  logic signed [AccW-1:0] ma, mb;
  logic dstart;
  logic signed [31:0] dn;
  logic signed [32:0] dd;
  logic launched;

  // operand selection per step
  always_comb begin
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    dstart = 1'b0;
    dn = n00;
    dd = 33'(n00) + 33'($signed({1'b0, r_noise}));
    case (state)
      S_ANG:  begin mstart = 1'b1; ma = AccW'(d); mb = AccW'($signed({1'b0, dt})); end
      S_M10:  begin mstart = 1'b1; ma = AccW'(p10); mb = AccW'($signed({1'b0, dt})); end
      S_M01:  begin mstart = 1'b1; ma = AccW'(p01); mb = AccW'($signed({1'b0, dt})); end
      S_M11:  begin mstart = 1'b1; ma = AccW'(p11); mb = AccW'($signed({1'b0, dt})); end
      S_M11B: begin mstart = 1'b1; ma = t11; mb = AccW'($signed({1'b0, dt})); end
      S_MQB:  begin mstart = 1'b1; ma = AccW'($signed({1'b0, q_bias}));
                    mb = AccW'($signed({1'b0, dt})); end
      S_DIV0: begin dstart = 1'b1; dn = n00; end
      S_DIV1: begin dstart = 1'b1; dn = n10; end
      S_KY0:  begin mstart = 1'b1; ma = AccW'(k0); mb = AccW'(y); end
      S_KY1:  begin mstart = 1'b1; ma = AccW'(k1); mb = AccW'(y); end
      S_KN0:  begin mstart = 1'b1; ma = AccW'(k0); mb = AccW'(n00); end
      S_KN1:  begin mstart = 1'b1; ma = AccW'(k0); mb = AccW'(n01); end
      S_KN2:  begin mstart = 1'b1; ma = AccW'(k1); mb = AccW'(n00); end
      S_KN3:  begin mstart = 1'b1; ma = AccW'(k1); mb = AccW'(n01); end
      default: ;
    endcase
    // launch once per step
    if (launched) begin
      mstart = 1'b0;
      dstart = 1'b0;
    end
  end

  // multiplier: multiplier operand is signed 34-bit, last bit weighs negative
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt <= '0;
    end else if (!mbusy && !dbusy && mstart) begin
      mbusy <= 1'b1;
      mcnt <= '0;
      macc <= '0;
      mcand <= ma;
      mplier <= mb[MulW-1:0];
    end else if (mbusy) begin
      if (mplier[0]) begin
        if (mcnt == MCntW'(MulW - 1)) macc <= macc - mcand;
        else macc <= macc + mcand;
      end
      mplier <= mplier >> 1;
      mcand <= mcand <<< 1;
      mcnt <= mcnt + 1'b1;
      if (mcnt == MCntW'(MulW - 1)) mbusy <= 1'b0;
    end
  end

  // divider: |num| << FRAC_BITS / den, one quotient bit per cycle
  logic [33:0] dtrial;
  assign dtrial = {drem, dnum[QW-1]} - {1'b0, dden};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt <= '0;
    end else if (!mbusy && !dbusy && dstart) begin
      dbusy <= 1'b1;
      dcnt <= '0;
      drem <= '0;
      dquo <= '0;
      dden <= dd;
      dneg <= dn[31];
      dnum <= QW'(dn[31] ? -33'(dn) : 33'(dn)) << FRAC_BITS;
    end else if (dbusy) begin
      if (!dtrial[33]) begin
        drem <= dtrial[32:0];
        dquo <= {dquo[QW-2:0], 1'b1};
      end else begin
        drem <= {drem[31:0], dnum[QW-1]};
        dquo <= {dquo[QW-2:0], 1'b0};
      end
      dnum <= dnum << 1;
      dcnt <= dcnt + 1'b1;
      if (dcnt == QCntW'(QW - 1)) dbusy <= 1'b0;
    end
  end

  logic signed [AccW-1:0] qsig;
  assign qsig = dneg ? -AccW'({1'b0, dquo}) : AccW'({1'b0, dquo});
  logic unit_done;
  assign unit_done = launched && !mbusy && !dbusy;
  logic dpos;
  assign dpos = (33'(n00) + 33'($signed({1'b0, r_noise}))) > 0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      launched <= 1'b0;
      out_valid <= 1'b0;
      ang <= '0;
      bias <= '0;
      p00 <= 32'sd1 <<< FRAC_BITS;
      p01 <= '0;
      p10 <= '0;
      p11 <= 32'sd1 <<< FRAC_BITS;
    end else begin
      if (mstart || dstart) launched <= 1'b1;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          z <= measured_angle;
          rate <= gyro_rate;
          state <= S_D;
        end
        S_D: begin
          d <= sat32(AccW'(rate) - AccW'(bias));
          state <= S_ANG;
        end
        S_ANG: if (unit_done) begin
          launched <= 1'b0;
          ang <= sat32(AccW'(ang) + mres);
          state <= S_M10;
        end
        S_M10: if (unit_done) begin launched <= 1'b0; t10 <= mres; state <= S_M01; end
        S_M01: if (unit_done) begin launched <= 1'b0; t01 <= mres; state <= S_M11; end
        S_M11: if (unit_done) begin launched <= 1'b0; t11 <= mres; state <= S_M11B; end
        S_M11B: if (unit_done) begin
          launched <= 1'b0;
          n00 <= sat32(AccW'(p00) - t10 - t01 + mres + AccW'($signed({1'b0, q_angle})));
          state <= S_MQB;
        end
        S_MQB: if (unit_done) begin launched <= 1'b0; tqb <= mres; state <= S_PRED; end
        S_PRED: begin
          n01 <= sat32(AccW'(p01) - t11);
          n10 <= sat32(AccW'(p10) - t11);
          n11 <= sat32(AccW'(p11) + tqb);
          y <= sat32(AccW'(z) - AccW'(ang));
          state <= S_DIV0;
        end
        S_DIV0: if (unit_done) begin
          launched <= 1'b0;
          k0 <= dpos ? sat32(qsig) : '0;
          state <= S_DIV1;
        end
        S_DIV1: if (unit_done) begin
          launched <= 1'b0;
          k1 <= dpos ? sat32(qsig) : '0;
          state <= S_KY0;
        end
        S_KY0: if (unit_done) begin
          launched <= 1'b0;
          ang <= sat32(AccW'(ang) + mres);
          state <= S_KY1;
        end
        S_KY1: if (unit_done) begin
          launched <= 1'b0;
          bias <= sat32(AccW'(bias) + mres);
          state <= S_KN0;
        end
        S_KN0: if (unit_done) begin
          launched <= 1'b0; p00 <= sat32(AccW'(n00) - mres); state <= S_KN1;
        end
        S_KN1: if (unit_done) begin
          launched <= 1'b0; p01 <= sat32(AccW'(n01) - mres); state <= S_KN2;
        end
        S_KN2: if (unit_done) begin
          launched <= 1'b0; p10 <= sat32(AccW'(n10) - mres); state <= S_KN3;
        end
        S_KN3: if (unit_done) begin
          launched <= 1'b0; p11 <= sat32(AccW'(n11) - mres); state <= S_DONE;
        end
        S_DONE: begin
          angle_estimate <= ang;
          bias_estimate <= bias;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst) !(mbusy && dbusy))
    else $error("multiplier and divider busy together");
  a_out_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result valid outside handoff");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mbusy && !dbusy) else $error("input ready while units busy");
endmodule

// File: sim/kalman_tilt_bias_estimator_unit_tb.sv
// Self-checking testbench for the tilt/bias Kalman estimator: directed and random samples.
module kalman_tilt_bias_estimator_unit_tb;
  import ktbe_pkg::*;

  typedef struct {
    int angle;
    int bias;
  } estimate_t;

  typedef struct {
    int   angle;
    int   rate;
    bit   known;
    int   exp_angle;
    int   exp_bias;
  } sample_row_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;

  kalman_tilt_bias_estimator_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .measured_angle(measured_angle),
    .gyro_rate(gyro_rate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angle_estimate(angle_estimate),
    .bias_estimate(bias_estimate)
  );

  // filter state mirrored here
  longint q_angle;
  longint q_bias;
  longint meas_noise;
  longint period;
  int angle_q;
  int bias_q;
  int cov[4];

  estimate_t estimates_due[$];
  int mismatch_count;
  bit send_idle;
  bit recv_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // rounded Q product, halves go up
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic int kalman_gain(input int num, input longint s);
    if (s <= 0) return 0;
    return clamp32((longint'(num) * 64'sd65536) / s);
  endfunction

  function automatic estimate_t predict_estimate(input int z, input int rate);
    longint p00, p01, p10, p11, s;
    int d, n00, n01, n10, n11, k0, k1, y;
    estimate_t e;
    p00 = cov[0];
    p01 = cov[1];
    p10 = cov[2];
    p11 = cov[3];
    d = clamp32(longint'(rate) - bias_q);
    angle_q = clamp32(longint'(angle_q) + qmul(d, period));
    n00 = clamp32(p00 - qmul(period, p10) - qmul(period, p01)
                  + qmul(period, qmul(period, p11)) + q_angle);
    n01 = clamp32(p01 - qmul(period, p11));
    n10 = clamp32(p10 - qmul(period, p11));
    n11 = clamp32(p11 + qmul(q_bias, period));
    y = clamp32(longint'(z) - angle_q);
    s = longint'(n00) + meas_noise;
    k0 = kalman_gain(n00, s);
    k1 = kalman_gain(n10, s);
    angle_q = clamp32(longint'(angle_q) + qmul(k0, y));
    bias_q = clamp32(longint'(bias_q) + qmul(k1, y));
    cov[0] = clamp32(longint'(n00) - qmul(k0, n00));
    cov[1] = clamp32(longint'(n01) - qmul(k0, n01));
    cov[2] = clamp32(longint'(n10) - qmul(k1, n00));
    cov[3] = clamp32(longint'(n11) - qmul(k1, n01));
    e.angle = angle_q;
    e.bias = bias_q;
    return e;
  endfunction

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint value);
    logic [CfgDataW-1:0] junk;
    junk = $urandom;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    if (idx == REG_DT) cfg_data <= {junk[31:17], value[16:0]};
    else cfg_data <= {junk[31], value[30:0]};
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_Q_ANGLE: q_angle = value & 64'h7FFF_FFFF;
      REG_Q_BIAS:  q_bias = value & 64'h7FFF_FFFF;
      REG_R:       meas_noise = value & 64'h7FFF_FFFF;
      default:     period = value & 64'h1_FFFF;
    endcase
    @(negedge clk);
  endtask

  task automatic send_sample(input int z, input int rate, input bit known,
                             input int exp_angle, input int exp_bias);
    int gap;
    estimate_t e;
    gap = send_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    measured_angle <= z;
    gyro_rate <= rate;
    do @(posedge clk); while (!in_ready);
    e = predict_estimate(z, rate);
    if (known && (e.angle != exp_angle || e.bias != exp_bias))
      $display("%0t: table row disagrees with prediction: %0d/%0d vs %0d/%0d",
               $time, exp_angle, exp_bias, e.angle, e.bias);
    if (known) begin
      e.angle = exp_angle;
      e.bias = exp_bias;
    end
    estimates_due.push_back(e);
    @(negedge clk);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (estimates_due.size() != 0) @(negedge clk);
  endtask

  function automatic int random_field(input int span);
    if ($urandom_range(0, 3) == 0) return int'($urandom);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  sample_row_t directed[] = '{
    '{0, 0, 1'b1, 0, 0},
    '{0, 0, 1'b0, 0, 0},
    '{32'sh7FFF_FFFF, 0, 1'b0, 0, 0},
    '{32'sh8000_0000, 0, 1'b0, 0, 0},
    '{0, 32'sh7FFF_FFFF, 1'b0, 0, 0},
    '{0, 32'sh8000_0000, 1'b0, 0, 0},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 0, 0},
    '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 0, 0},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 0, 0},
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 0, 0},
    '{-1, 1, 1'b0, 0, 0},
    '{1, -1, 1'b0, 0, 0},
    '{32'sh0005_0000, 32'sh0000_8000, 1'b0, 0, 0},
    '{-32'sh0005_0000, -32'sh0000_8000, 1'b0, 0, 0},
    '{32'sh005A_0000, 32'sh00FA_0000, 1'b0, 0, 0},
    '{32'shFFA6_0000, 32'shFF06_0000, 1'b0, 0, 0}
  };

  // receive side
  initial begin
    int stall;
    estimate_t e;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = recv_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (estimates_due.size() == 0) begin
        $display("%0t: unexpected result angle=%0d bias=%0d", $time,
                 angle_estimate, bias_estimate);
        mismatch_count++;
      end else begin
        e = estimates_due.pop_front();
        if (angle_estimate !== e.angle) begin
          $display("%0t: angle_estimate expected %0d actual %0d", $time, e.angle,
                   angle_estimate);
          mismatch_count++;
        end
        if (bias_estimate !== e.bias) begin
          $display("%0t: bias_estimate expected %0d actual %0d", $time, e.bias,
                   bias_estimate);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mismatch_count = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    measured_angle = '0;
    gyro_rate = '0;
    q_angle = RST_Q_ANGLE;
    q_bias = RST_Q_BIAS;
    meas_noise = RST_R;
    period = RST_DT;
    angle_q = 0;
    bias_q = 0;
    cov = '{65536, 0, 0, 65536};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i])
      send_sample(directed[i].angle, directed[i].rate, directed[i].known,
                  directed[i].exp_angle, directed[i].exp_bias);

    for (int ph = 0; ph < 10; ph++) begin
      // hold input until every result is back, then reconfigure
      wait_drained();
      case (ph)
        0: begin
          write_reg(REG_Q_ANGLE, 64'h7FFF_FFFF);
          write_reg(REG_Q_BIAS, 64'h7FFF_FFFF);
          write_reg(REG_R, 64'h7FFF_FFFF);
          write_reg(REG_DT, 64'h1_0000);
        end
        1: begin
          write_reg(REG_Q_ANGLE, 0);
          write_reg(REG_Q_BIAS, 0);
          write_reg(REG_R, 1);
          write_reg(REG_DT, 1);
        end
        2: begin
          // zero period: prediction adds only noise
          write_reg(REG_DT, 0);
          write_reg(REG_R, 32768);
          write_reg(REG_Q_ANGLE, 66);
        end
        3: begin
          // zero measurement noise with zero angle noise can drive S to zero
          write_reg(REG_R, 0);
          write_reg(REG_Q_ANGLE, 0);
          write_reg(REG_DT, 64'h1_FFFF);
        end
        4: begin
          write_reg(REG_Q_ANGLE, RST_Q_ANGLE);
          write_reg(REG_Q_BIAS, RST_Q_BIAS);
          write_reg(REG_R, RST_R);
          write_reg(REG_DT, RST_DT);
        end
        default: begin
          write_reg(REG_Q_ANGLE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096));
          write_reg(REG_Q_BIAS, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096));
          write_reg(REG_R, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 18));
          write_reg(REG_DT, $urandom_range(0, 131071));
        end
      endcase
      cfg_valid <= 1'b0;
      send_idle = (ph % 3) != 1;
      recv_idle = (ph % 4) != 2;
      repeat (200) send_sample(random_field(6_000_000), random_field(20_000_000),
                               1'b0, 0, 0);
    end

    in_valid <= 1'b0;
    while (estimates_due.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (mismatch_count == 0 && estimates_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
